### rtl/core/prst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Prefix range search package
// Shared function codes and match total width for the prefix range search block.
// ----------------------------------------------------------------------------
package prst_pkg;

	typedef enum logic [1:0] {
		FUNC_LOAD  = 2'd0,
		FUNC_QUERY = 2'd1,
		FUNC_CLEAR = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	localparam int unsigned TOTAL_W = 11;

endpackage
`default_nettype wire

### rtl/core/prefix_range_search_topk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Prefix range search with top-K selection
// Sorted key table searched by prefix; best matches emitted by frequency.
// ----------------------------------------------------------------------------
// Loads and clears produce no result beat.
// A query runs a binary search (a read and a compare state per probe), grows
// the range (a read and a compare state per entry), then runs up to TOP_K
// selection passes that each scan every entry in range and fetch the winner, all on one read port.
// Only one beat is in work at a time; tready is low until it is done.
// Reset clears the entry count and the sequencer; table contents stay.

module prefix_range_search_topk #(
	parameter int unsigned TABLE_DEPTH = 1024,
	parameter int unsigned KEY_BYTES   = 8,
	parameter int unsigned TOP_K       = 10
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// key[63:0], key_len[67:64], freq[99:68], zero fill to 104
	input  wire logic [103:0] s_tdata,
	// func[1:0]
	input  wire logic [1:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// match_key[63:0], match_freq[95:64], match_total[106:96], zero fill to 112
	output logic [111:0]      m_tdata,
	// found[0]
	output logic              m_tuser,
	output logic              m_tlast
);

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned KW = (TOP_K > 1) ? $clog2(TOP_K + 1) : 1;
	localparam int unsigned KB = 8 * KEY_BYTES;
	localparam int unsigned TW = prst_pkg::TOTAL_W;
	localparam logic [63:0] KEY_MASK = 64'((65'd1 << KB) - 65'd1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_BS_RD, ST_BS_CMP, ST_LO_RD, ST_LO_CMP, ST_HI_RD, ST_HI_CMP,
		ST_SEL_RD, ST_SEL_CMP, ST_OUT_RD, ST_OUT_WAIT, ST_OUT, ST_MISS
	} state_t;

	state_t          state_q;
	logic [63:0]     key_mem [TABLE_DEPTH];
	logic [31:0]     freq_mem [TABLE_DEPTH];
	logic [63:0]     rd_key_q;
	logic [31:0]     rd_freq_q;
	logic [AW-1:0]   rd_addr;
	logic [CW-1:0]   count_q;
	logic [63:0]     mask_q, query_q;
	logic [CW:0]     low_q, up_q;
	logic [CW-1:0]   mid_q, lo_q, hi_q, scan_q;
	logic [AW-1:0]   best_q, prev_q;
	logic [31:0]     best_f_q, prev_f_q;
	logic            have_best_q, have_prev_q;
	logic [KW-1:0]   k_q, want_q;
	logic [CW-1:0]   total;
	logic [TW-1:0]   total_sat;
	logic            hit;
	logic            before_prev, beats_best;

	logic [1:0]      in_func;
	logic [63:0]     in_key;
	logic [3:0]      in_len;
	logic [31:0]     in_freq;
	logic [3:0]      len_sat;
	logic [63:0]     in_mask;

	assign in_func = s_tuser;
	assign in_key  = s_tdata[63:0];
	assign in_len  = s_tdata[67:64];
	assign in_freq = s_tdata[99:68];
	assign len_sat = (in_len > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : in_len;

	always_comb begin
		in_mask = '0;
		for (int b = 0; b < 8; b++) begin
			if (b < KEY_BYTES && (KEY_BYTES - 1 - b) < len_sat) begin
				in_mask[8*b +: 8] = 8'hFF;
			end
		end
	end

	assign hit = ((rd_key_q & mask_q) == query_q);
	assign total = hi_q - lo_q + 1'b1;
	assign total_sat = (CW > TW && total > CW'((1 << TW) - 1)) ? '1 : TW'(total);

	// Candidate scan_q ranks after prev, and ahead of the best so far.
	assign before_prev = !have_prev_q || (prev_f_q > rd_freq_q) ||
		(prev_f_q == rd_freq_q && CW'(prev_q) < scan_q);
	assign beats_best = !have_best_q || (rd_freq_q > best_f_q);

	always_comb begin
		case (state_q)
			ST_LO_RD:  rd_addr = AW'(lo_q - 1'b1);
			ST_HI_RD:  rd_addr = AW'(hi_q + 1'b1);
			ST_SEL_RD: rd_addr = AW'(scan_q);
			ST_OUT_RD: rd_addr = best_q;
			default:   rd_addr = AW'(mid_q);
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid && in_func == prst_pkg::FUNC_LOAD &&
				count_q < CW'(TABLE_DEPTH)) begin
			key_mem[AW'(count_q)]  <= in_key & KEY_MASK;
			freq_mem[AW'(count_q)] <= in_freq;
		end
		rd_key_q  <= key_mem[rd_addr];
		rd_freq_q <= freq_mem[rd_addr];
	end

	assign s_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			m_tvalid <= 1'b0;
			m_tlast  <= 1'b0;
			m_tdata  <= '0;
			m_tuser  <= 1'b0;
			mask_q <= '0; query_q <= '0; low_q <= '0; up_q <= '0; mid_q <= '0;
			lo_q <= '0; hi_q <= '0; scan_q <= '0; best_q <= '0; prev_q <= '0;
			best_f_q <= '0; prev_f_q <= '0; have_best_q <= 1'b0;
			have_prev_q <= 1'b0; k_q <= '0; want_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						case (in_func)
							prst_pkg::FUNC_LOAD: begin
								if (count_q < CW'(TABLE_DEPTH)) count_q <= count_q + 1'b1;
							end
							prst_pkg::FUNC_CLEAR: count_q <= '0;
							prst_pkg::FUNC_QUERY: begin
								mask_q  <= in_mask;
								query_q <= in_key & in_mask;
								low_q   <= '0;
								up_q    <= {1'b0, count_q} - 1'b1;
								mid_q   <= CW'(({1'b0, count_q} - 1'b1) >> 1);
								state_q <= (count_q == '0) ? ST_MISS : ST_BS_RD;
							end
							default: ;
						endcase
					end
				end
				ST_BS_RD: state_q <= ST_BS_CMP;
				ST_BS_CMP: begin
					if (hit) begin
						lo_q <= mid_q;
						hi_q <= mid_q;
						state_q <= (mid_q == '0) ? ST_HI_RD : ST_LO_RD;
					end else if (query_q < (rd_key_q & mask_q)) begin
						if ({1'b0, mid_q} == low_q) begin
							state_q <= ST_MISS;
						end else begin
							up_q  <= {1'b0, mid_q} - 1'b1;
							mid_q <= CW'((low_q + {1'b0, mid_q} - 1'b1) >> 1);
							state_q <= ST_BS_RD;
						end
					end else begin
						if ({1'b0, mid_q} == up_q) begin
							state_q <= ST_MISS;
						end else begin
							low_q <= {1'b0, mid_q} + 1'b1;
							mid_q <= CW'(({1'b0, mid_q} + 1'b1 + up_q) >> 1);
							state_q <= ST_BS_RD;
						end
					end
				end
				ST_LO_RD: state_q <= ST_LO_CMP;
				ST_LO_CMP: begin
					if (hit) begin
						lo_q <= lo_q - 1'b1;
						state_q <= (lo_q == CW'(1)) ? ST_HI_RD : ST_LO_RD;
					end else begin
						state_q <= ST_HI_RD;
					end
				end
				ST_HI_RD: begin
					if (hi_q + 1'b1 >= count_q) begin
						state_q <= ST_SEL_RD;
						scan_q <= lo_q;
						have_best_q <= 1'b0;
						have_prev_q <= 1'b0;
						k_q <= '0;
						want_q <= (total < CW'(TOP_K)) ? KW'(total) : KW'(TOP_K);
					end else begin
						state_q <= ST_HI_CMP;
					end
				end
				ST_HI_CMP: begin
					if (hit) hi_q <= hi_q + 1'b1;
					else hi_q <= hi_q;
					if (hit) state_q <= ST_HI_RD;
					else begin
						state_q <= ST_SEL_RD;
						scan_q <= lo_q;
						have_best_q <= 1'b0;
						have_prev_q <= 1'b0;
						k_q <= '0;
						want_q <= (total < CW'(TOP_K)) ? KW'(total) : KW'(TOP_K);
					end
				end
				ST_SEL_RD: state_q <= ST_SEL_CMP;
				ST_SEL_CMP: begin
					if (before_prev && beats_best) begin
						best_q <= AW'(scan_q);
						best_f_q <= rd_freq_q;
						have_best_q <= 1'b1;
					end
					if (scan_q == hi_q) state_q <= ST_OUT_RD;
					else begin
						scan_q <= scan_q + 1'b1;
						state_q <= ST_SEL_RD;
					end
				end
				ST_OUT_RD: state_q <= ST_OUT_WAIT;
				ST_OUT_WAIT: begin
					m_tvalid <= 1'b1;
					m_tlast  <= (k_q + 1'b1 == want_q);
					m_tdata  <= {{(112-96-TW){1'b0}}, total_sat, rd_freq_q, rd_key_q};
					m_tuser  <= 1'b1;
					state_q  <= ST_OUT;
				end
				ST_OUT: begin
					if (m_tready) begin
						m_tvalid <= 1'b0;
						if (m_tlast) state_q <= ST_IDLE;
						else begin
							k_q <= k_q + 1'b1;
							prev_q <= best_q;
							prev_f_q <= best_f_q;
							have_prev_q <= 1'b1;
							have_best_q <= 1'b0;
							scan_q <= lo_q;
							state_q <= ST_SEL_RD;
						end
					end
				end
				ST_MISS: begin
					if (!m_tvalid) begin
						m_tvalid <= 1'b1;
						m_tlast  <= 1'b1;
						m_tdata  <= '0;
						m_tuser  <= 1'b0;
					end else if (m_tready) begin
						m_tvalid <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");
	a_busy_no_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input ready while a result is pending");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count above table depth");
	a_range_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEL_CMP |-> lo_q <= hi_q && hi_q < count_q)
		else $error("match range malformed");

endmodule
`default_nettype wire
